// ===== rtl/vigenere_stream_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
// VSD_ASSERT checks on every clock edge outside reset.
// VSD_ASSERT_NORST also checks on edges while reset is applied.
// VSD_ASSERT expects i_clk and i_rst_n in the enclosing module; VSD_ASSERT_NORST uses only i_clk.
`ifndef VIGENERE_STREAM_DECODER_ASSERT_SVH
`define VIGENERE_STREAM_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define VSD_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("vsd assertion failed");
`define VSD_ASSERT_NORST(lbl, prop) lbl: assert property (@(posedge i_clk) prop) \
    else $error("vsd reset assertion failed");
`else
`define VSD_ASSERT(lbl, prop)
`define VSD_ASSERT_NORST(lbl, prop)
`endif
`endif

// ===== rtl/vsd_pkg.sv =====
package vsd_pkg;

    localparam int CHAR_W           = 8;
    localparam int LETTER_W         = 5;
    localparam int MAX_KEY_LETTERS  = 24;
    localparam int LETTERS_PER_WORD = 12;
    localparam int ALPHABET_LETTERS = 26;
    localparam int CFG_DATA_W       = 60;
    localparam int CFG_IDX_W        = 2;

    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [LETTER_W-1:0]   t_letter;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_KEY_LOW    = 2'd0;
    localparam t_cfg_idx CFG_KEY_HIGH   = 2'd1;
    localparam t_cfg_idx CFG_KEY_LENGTH = 2'd2;

    localparam t_letter KEY_LEN_RESET = 5'd1;
    localparam t_letter KEY_LEN_MAX   = 5'(MAX_KEY_LETTERS);
    localparam t_letter ALPHABET_L    = 5'(ALPHABET_LETTERS);

    localparam t_char ASCII_UPPER_A = 8'h41;
    localparam t_char ASCII_UPPER_Z = 8'h5A;
    localparam t_char ASCII_LOWER_A = 8'h61;
    localparam t_char ASCII_LOWER_Z = 8'h7A;

    // control into one key cell: per-cell position info plus shared strobes
    typedef struct packed {
        logic home;       // first cell of the ring
        logic active;     // cell index below the effective key length
        logic last;       // cell index equals effective key length minus one
        logic use_first;  // select the first cell regardless of the token
        logic advance;    // a letter transaction: move the token on
        logic restart;    // message start on a non-letter: token home
    } t_cell_ctrl;

    typedef struct packed {
        logic tok;
        logic hit;
        logic sel;
        logic pass;
        logic wrap;
    } t_cell_stat;

    function automatic logic is_upper(input t_char ch);
        return (ch >= ASCII_UPPER_A) && (ch <= ASCII_UPPER_Z);
    endfunction

    function automatic logic is_lower(input t_char ch);
        return (ch >= ASCII_LOWER_A) && (ch <= ASCII_LOWER_Z);
    endfunction

    // k is already reduced to 0..25
    function automatic t_char decode_char(input t_char ch, input t_letter k);
        t_char       base;
        t_char       off;
        logic [5:0]  t;
        t_char       res;
        base = is_upper(ch) ? ASCII_UPPER_A : ASCII_LOWER_A;
        off  = ch - base;
        // c + 25 - k lies in 0..50, one conditional subtract brings it below 26
        t = {1'b0, off[LETTER_W-1:0]} + 6'(ALPHABET_LETTERS - 1) - {1'b0, k};
        if (t >= 6'(ALPHABET_LETTERS)) begin
            t = t - 6'(ALPHABET_LETTERS);
        end
        res = ch;
        if (is_upper(ch) || is_lower(ch)) begin
            res = base + {2'b00, t};
        end
        return res;
    endfunction

endpackage

// ===== rtl/vsd_if.sv =====
interface vsd_cipher_if;
    logic                 valid;
    logic                 ready;
    logic [vsd_pkg::CHAR_W-1:0] cipher_char;
    logic                 message_start;

    modport source (output valid, output cipher_char, output message_start, input ready);
    modport sink   (input valid, input cipher_char, input message_start, output ready);
endinterface

interface vsd_plain_if;
    logic                 valid;
    logic                 ready;
    logic [vsd_pkg::CHAR_W-1:0] plain_char;

    modport source (output valid, output plain_char, input ready);
    modport sink   (input valid, input plain_char, output ready);
endinterface

interface vsd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vsd_pkg::CFG_IDX_W-1:0]  index;
    logic [vsd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/vsd_key_cell.sv =====
module vsd_key_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vsd_pkg::t_cell_ctrl  i_ctrl,
    input  logic                 i_cfg_we,
    input  vsd_pkg::t_letter     i_cfg_letter,
    input  logic                 i_pass_in,
    output vsd_pkg::t_cell_stat  o_stat,
    output vsd_pkg::t_letter     o_key
);
    import vsd_pkg::*;

    logic    r_tok;
    logic    n_tok;
    t_letter r_key;
    t_letter w_key_mod;
    logic    w_sel;

    always_comb begin
        w_key_mod = (r_key >= ALPHABET_L) ? (r_key - ALPHABET_L) : r_key;
        // a token parked beyond the key length falls back to the first cell
        w_sel = i_ctrl.use_first ? i_ctrl.home : (r_tok & i_ctrl.active);
    end

    assign o_stat.tok  = r_tok;
    assign o_stat.hit  = r_tok & i_ctrl.active;
    assign o_stat.sel  = w_sel;
    assign o_stat.pass = w_sel & ~i_ctrl.last;
    assign o_stat.wrap = w_sel & i_ctrl.last;
    assign o_key       = w_sel ? w_key_mod : '0;

    always_comb begin
        priority if (i_ctrl.advance) begin
            n_tok = i_pass_in;
        end else if (i_ctrl.restart) begin
            n_tok = i_ctrl.home;
        end else begin
            n_tok = r_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= i_ctrl.home;
            r_key <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_cfg_we) begin
                r_key <= i_cfg_letter;
            end
        end
    end

endmodule

// ===== rtl/vsd_out_skid.sv =====
module vsd_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  vsd_pkg::t_char   i_data,
    output logic             o_ready,
    vsd_plain_if.source      o_plain
);
    import vsd_pkg::*;

    logic  r_out_valid;
    logic  n_out_valid;
    t_char r_out_data;
    t_char n_out_data;
    logic  r_skid_valid;
    logic  n_skid_valid;
    t_char r_skid_data;
    t_char n_skid_data;

    assign o_ready          = ~r_skid_valid;
    assign o_plain.valid      = r_out_valid;
    assign o_plain.plain_char = r_out_data;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_out_valid && o_plain.ready) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_valid && !r_skid_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

endmodule

// ===== rtl/vigenere_stream_decoder.sv =====
// Streaming repeating-key letter decoder, one ASCII byte per transaction.
// i_cipher: cipher_char plus message_start, which restarts the key at its
//   first letter before this byte. o_plain: one plain_char per input byte.
// i_cfg: register writes (index 0/1 = key letters 0..11 / 12..23, five bits
//   each; index 2 = key length). Always ready; write only while idle.
// Each result is registered in the output register or the skid entry.
// Throughput: one byte per cycle unless the output stalls. The key
//   position is a token passed along a ring of 24 key cells, one hop per
//   letter, so consecutive bytes never wait on each other.
// Letters of either case are decoded with case kept; other bytes pass
//   through and leave the key position alone.
// Reset: key letters 0, key length 1, token in the first cell, output empty.
//   No clearing pass; the block takes input straight after reset.
// Stall: an output register plus a skid entry hold up to two results; input
//   ready drops only when both are full and is driven from a register.
`include "vigenere_stream_decoder_assert.svh"

module vigenere_stream_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vsd_cipher_if.sink   i_cipher,
    vsd_plain_if.source  o_plain,
    vsd_cfg_if.sink      i_cfg
);
    import vsd_pkg::*;

    t_letter    r_len_raw;
    t_letter    w_len_eff;
    logic       w_acc;
    logic       w_letter;
    logic       w_use_first;
    logic       w_wrap_any;
    logic       w_in_ready;
    t_letter    w_key;
    t_char      w_plain;

    t_cell_ctrl w_ctrl [MAX_KEY_LETTERS];
    t_cell_stat w_stat [MAX_KEY_LETTERS];
    t_letter    w_cell_key [MAX_KEY_LETTERS];
    logic [MAX_KEY_LETTERS-1:0] w_tok;
    logic [MAX_KEY_LETTERS-1:0] w_hit;
    logic [MAX_KEY_LETTERS-1:0] w_sel;
    logic [MAX_KEY_LETTERS-1:0] w_pass;
    logic [MAX_KEY_LETTERS-1:0] w_wrap;
    logic [MAX_KEY_LETTERS-1:0] w_pass_in;

    assign i_cfg.ready    = 1'b1;
    assign i_cipher.ready = w_in_ready;
    assign w_acc          = i_cipher.valid & w_in_ready;
    assign w_letter       = is_upper(i_cipher.cipher_char) | is_lower(i_cipher.cipher_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_raw <= KEY_LEN_RESET;
        end else if (i_cfg.valid && (i_cfg.index == CFG_KEY_LENGTH)) begin
            r_len_raw <= i_cfg.data[LETTER_W-1:0];
        end
    end

    always_comb begin
        priority if (r_len_raw == '0) begin
            w_len_eff = KEY_LEN_RESET;
        end else if (r_len_raw > KEY_LEN_MAX) begin
            w_len_eff = KEY_LEN_MAX;
        end else begin
            w_len_eff = r_len_raw;
        end
    end

    assign w_use_first = i_cipher.message_start | ~(|w_hit);
    assign w_wrap_any  = |w_wrap;

    genvar g;
    generate
        for (g = 0; g < MAX_KEY_LETTERS; g++) begin : g_cell
            localparam int        SLOT    = g % LETTERS_PER_WORD;
            localparam t_cfg_idx  WORD_ID = (g < LETTERS_PER_WORD) ? CFG_KEY_LOW : CFG_KEY_HIGH;

            assign w_ctrl[g].home      = (g == 0);
            assign w_ctrl[g].active    = (t_letter'(g) < w_len_eff);
            assign w_ctrl[g].last      = (t_letter'(g + 1) == w_len_eff);
            assign w_ctrl[g].use_first = w_use_first;
            assign w_ctrl[g].advance   = w_acc & w_letter;
            assign w_ctrl[g].restart   = w_acc & i_cipher.message_start;

            if (g == 0) begin : g_home
                assign w_pass_in[g] = w_pass[MAX_KEY_LETTERS-1] | w_wrap_any;
            end else begin : g_link
                assign w_pass_in[g] = w_pass[g-1];
            end

            vsd_key_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl[g]),
                .i_cfg_we     (i_cfg.valid && (i_cfg.index == WORD_ID)),
                .i_cfg_letter (i_cfg.data[SLOT*LETTER_W +: LETTER_W]),
                .i_pass_in    (w_pass_in[g]),
                .o_stat       (w_stat[g]),
                .o_key        (w_cell_key[g])
            );

            assign w_tok[g]  = w_stat[g].tok;
            assign w_hit[g]  = w_stat[g].hit;
            assign w_sel[g]  = w_stat[g].sel;
            assign w_pass[g] = w_stat[g].pass;
            assign w_wrap[g] = w_stat[g].wrap;
        end
    endgenerate

    // only the selected cell drives a nonzero letter
    always_comb begin
        w_key = '0;
        for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
            w_key = w_key | w_cell_key[i];
        end
    end

    assign w_plain = decode_char(i_cipher.cipher_char, w_key);

    vsd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_data  (w_plain),
        .o_ready (w_in_ready),
        .o_plain (o_plain)
    );

    `VSD_ASSERT(a_tok_onehot, $onehot(w_tok))
    `VSD_ASSERT(a_sel_onehot, $onehot(w_sel))
    `VSD_ASSERT(a_start_first, (w_acc && i_cipher.message_start) |-> w_sel[0])
    `VSD_ASSERT(a_skip_holds, (w_acc && !w_letter && !i_cipher.message_start) |=> $stable(w_tok))
    `VSD_ASSERT_NORST(a_reset_home, (!i_rst_n) |=> (w_tok[0] && !o_plain.valid))

endmodule
